[design/ecal_pkg.sv]
// Package for the epoch-seconds to calendar converter: types and constants.
`default_nettype none

package ecal_pkg;

    // Payload types, at the widths of the channel fields.
    typedef logic [31:0] t_epoch;
    typedef logic [15:0] t_days;
    typedef logic [16:0] t_sod;
    typedef logic [4:0]  t_hour;
    typedef logic [5:0]  t_min;
    typedef logic [11:0] t_year;
    typedef logic [3:0]  t_month;
    typedef logic [4:0]  t_dom;

    // Pipeline depth: three stages split off whole days, six more split day and time.
    localparam int ECAL_DEPTH = 9;
    localparam int ECAL_HEAD  = 3;
    localparam int ECAL_TAIL  = ECAL_DEPTH - ECAL_HEAD;

    // 86400 = 128 * 675; the low seven bits bypass the division.
    localparam int          ECAL_DAY_SHIFT = 7;
    localparam logic [9:0]  ECAL_DAY_ODD   = 10'd675;
    // floor(2^32 / 675).
    localparam logic [22:0] ECAL_DAY_RECIP = 23'd6362914;
    // 1980-01-06 is day 5 when days count from 1980-01-01.
    localparam logic [15:0] ECAL_EPOCH_OFS = 16'd5;

    // floor(2^24 / 60).
    localparam logic [18:0] ECAL_MIN_RECIP = 19'd279620;
    localparam logic [6:0]  ECAL_SIXTY     = 7'd60;

    // floor(2^26 / 1461).
    localparam logic [15:0] ECAL_QUAD_RECIP = 16'd45933;
    localparam logic [11:0] ECAL_QUAD_DAYS  = 12'd1461;
    localparam logic [10:0] ECAL_LEAP_DAYS  = 11'd366;
    localparam logic [10:0] ECAL_YEAR_DAYS  = 11'd365;
    localparam logic [10:0] ECAL_TWO_YEARS  = 11'd730;
    localparam t_year       ECAL_BASE_YEAR  = 12'd1980;

endpackage

`default_nettype wire

[design/ecal_in_if.sv]
// Input channel interface: one epoch timestamp per item.
`default_nettype none

interface ecal_in_if import ecal_pkg::*; ();
    logic   valid;
    logic   ready;
    t_epoch epoch_seconds;

    modport source (output valid, output epoch_seconds, input ready);
    modport sink   (input valid, input epoch_seconds, output ready);
endinterface

`default_nettype wire

[design/ecal_out_if.sv]
// Output channel interface: time of day and calendar date per item.
`default_nettype none

interface ecal_out_if import ecal_pkg::*; ();
    logic   valid;
    logic   ready;
    t_hour  hour;
    t_min   minute;
    t_min   second;
    t_year  year;
    t_month month;
    t_dom   day_of_month;

    modport source (output valid, output hour, output minute, output second,
                    output year, output month, output day_of_month, input ready);
    modport sink   (input valid, input hour, input minute, input second,
                    input year, input month, input day_of_month, output ready);
endinterface

`default_nettype wire

[design/epoch_seconds_to_calendar_top.sv]
// Top level of the epoch-seconds to calendar converter: day split and pipeline control.
//
//   Channel  Direction  Modport         Payload
//   i_in     in         ecal_in_if      epoch_seconds[31:0]
//   o_out    out        ecal_out_if     hour, minute, second, year, month, day_of_month
//
// The converter takes one item per clock cycle while the output is not stalled; the nine
// register stages each hold one multiply or one subtract-and-compare, and every item
// passes through all of them in order before its result is delivered.
// Reset clears only the stage valid bits; the data registers need no reset.
// Each stage loads when it is empty or when the stage behind it loads, so a stall at
// the output fills the empty stages first and no item is lost or repeated.
`default_nettype none

module epoch_seconds_to_calendar_top import ecal_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ecal_in_if.sink       i_in,
    ecal_out_if.source    o_out
);

    // One valid bit travels with each stage of the pipeline.
    logic [ECAL_DEPTH-1:0] r_vld;
    logic [ECAL_DEPTH-1:0] load;

    // Whole days come from (t >> 7) / 675, estimated low by at most one and then
    // fixed; the seconds of the day are the fixed remainder joined to the low bits.
    logic [24:0] r_s1_x;
    logic [6:0]  r_s1_lo;
    t_days       r_s1_q;
    t_days       r_s2_q;
    logic [10:0] r_s2_r;
    logic [6:0]  r_s2_lo;
    t_days       r_s3_days;
    t_sod        r_s3_sod;

    logic [47:0] n_p_day;
    logic [24:0] n_r_full;
    logic        n_r_ge;
    logic [9:0]  n_r_fix;

    // The load chain runs from the output back to the input.
    always_comb begin
        load[ECAL_DEPTH-1] = !r_vld[ECAL_DEPTH-1] || o_out.ready;
        for (int k = ECAL_DEPTH - 2; k >= 0; k--) begin
            load[k] = !r_vld[k] || load[k+1];
        end
    end

    assign i_in.ready  = load[0];
    assign o_out.valid = r_vld[ECAL_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (load[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < ECAL_DEPTH; k++) begin
                if (load[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign n_p_day  = 48'(i_in.epoch_seconds[31:ECAL_DAY_SHIFT]) * 48'(ECAL_DAY_RECIP);
    assign n_r_full = r_s1_x - 25'(25'(r_s1_q) * 25'(ECAL_DAY_ODD));
    assign n_r_ge   = (r_s2_r >= 11'(ECAL_DAY_ODD));
    assign n_r_fix  = n_r_ge ? 10'(r_s2_r - 11'(ECAL_DAY_ODD)) : r_s2_r[9:0];

    always_ff @(posedge i_clk) begin
        if (load[0]) begin
            r_s1_x  <= i_in.epoch_seconds[31:ECAL_DAY_SHIFT];
            r_s1_lo <= i_in.epoch_seconds[ECAL_DAY_SHIFT-1:0];
            r_s1_q  <= n_p_day[47:32];
        end
        if (load[1]) begin
            r_s2_q  <= r_s1_q;
            r_s2_r  <= n_r_full[10:0];
            r_s2_lo <= r_s1_lo;
        end
        if (load[2]) begin
            r_s3_days <= r_s2_q + 16'(n_r_ge) + ECAL_EPOCH_OFS;
            r_s3_sod  <= {n_r_fix, r_s2_lo};
        end
    end

    // The time of day and the date go down parallel tracks of equal depth.
    ecal_tod u_tod (
        .i_clk    (i_clk),
        .i_load   (load[ECAL_DEPTH-1:ECAL_HEAD]),
        .i_sod    (r_s3_sod),
        .o_hour   (o_out.hour),
        .o_minute (o_out.minute),
        .o_second (o_out.second)
    );

    ecal_date u_date (
        .i_clk          (i_clk),
        .i_load         (load[ECAL_DEPTH-1:ECAL_HEAD]),
        .i_days         (r_s3_days),
        .o_year         (o_out.year),
        .o_month        (o_out.month),
        .o_day_of_month (o_out.day_of_month)
    );

endmodule

`default_nettype wire

[design/ecal_tod.sv]
// Time-of-day pipeline: splits seconds of the day into hour, minute and second.
`default_nettype none

module ecal_tod import ecal_pkg::*; (
    input  logic                 i_clk,
    input  logic [ECAL_TAIL-1:0] i_load,
    input  t_sod                 i_sod,
    output t_hour                o_hour,
    output t_min                 o_minute,
    output t_min                 o_second
);

    // Minute of the day is estimated by a reciprocal multiply, then corrected once.
    t_sod        r_t4_sod;
    logic [10:0] r_t4_mest;
    logic [10:0] r_t5_mest;
    logic [6:0]  r_t5_rm;
    logic [10:0] r_t6_mod;
    t_min        r_t6_sec;
    logic [10:0] r_t7_mod;
    t_hour       r_t7_hest;
    t_min        r_t7_sec;
    t_hour       r_t8_hest;
    logic [6:0]  r_t8_rmin;
    t_min        r_t8_sec;
    t_hour       r_hour;
    t_min        r_minute;
    t_min        r_second;

    logic [35:0] n_p_mod;
    logic [16:0] n_rm_full;
    logic        n_rm_ge;
    logic [29:0] n_p_hour;
    logic [10:0] n_rmin_full;
    logic        n_rmin_ge;

    assign n_p_mod     = 36'(i_sod) * 36'(ECAL_MIN_RECIP);
    assign n_rm_full   = r_t4_sod - 17'(17'(r_t4_mest) * 17'(ECAL_SIXTY));
    assign n_rm_ge     = (r_t5_rm >= ECAL_SIXTY);
    assign n_p_hour    = 30'(r_t6_mod) * 30'(ECAL_MIN_RECIP);
    assign n_rmin_full = r_t7_mod - 11'(11'(r_t7_hest) * 11'(ECAL_SIXTY));
    assign n_rmin_ge   = (r_t8_rmin >= ECAL_SIXTY);

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_t4_sod  <= i_sod;
            r_t4_mest <= n_p_mod[34:24];
        end
        if (i_load[1]) begin
            r_t5_mest <= r_t4_mest;
            r_t5_rm   <= n_rm_full[6:0];
        end
        if (i_load[2]) begin
            r_t6_mod <= r_t5_mest + 11'(n_rm_ge);
            r_t6_sec <= n_rm_ge ? 6'(r_t5_rm - ECAL_SIXTY) : r_t5_rm[5:0];
        end
        if (i_load[3]) begin
            r_t7_mod  <= r_t6_mod;
            r_t7_hest <= n_p_hour[28:24];
            r_t7_sec  <= r_t6_sec;
        end
        if (i_load[4]) begin
            r_t8_hest <= r_t7_hest;
            r_t8_rmin <= n_rmin_full[6:0];
            r_t8_sec  <= r_t7_sec;
        end
        if (i_load[5]) begin
            r_hour   <= r_t8_hest + 5'(n_rmin_ge);
            r_minute <= n_rmin_ge ? 6'(r_t8_rmin - ECAL_SIXTY) : r_t8_rmin[5:0];
            r_second <= r_t8_sec;
        end
    end

    assign o_hour   = r_hour;
    assign o_minute = r_minute;
    assign o_second = r_second;

endmodule

`default_nettype wire

[design/ecal_date.sv]
// Date pipeline: splits a day count into year, month and day of month.
`default_nettype none

module ecal_date import ecal_pkg::*; (
    input  logic                 i_clk,
    input  logic [ECAL_TAIL-1:0] i_load,
    input  t_days                i_days,
    output t_year                o_year,
    output t_month               o_month,
    output t_dom                 o_day_of_month
);

    // First day of each month in a common year.
    localparam logic [8:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    t_days       r_d4_days;
    logic [5:0]  r_d4_qest;
    logic [5:0]  r_d5_qest;
    logic [11:0] r_d5_rq;
    logic [5:0]  r_d6_quad;
    logic [10:0] r_d6_rem;
    logic [5:0]  r_d7_quad;
    logic [1:0]  r_d7_yq;
    logic [8:0]  r_d7_doy;
    logic        r_d7_leap;
    t_year       r_d8_year;
    t_month      r_d8_month;
    t_dom        r_d8_dom;
    t_year       r_year;
    t_month      r_month;
    t_dom        r_dom;

    logic [31:0] n_p_quad;
    logic [15:0] n_rq_full;
    logic        n_rq_ge;
    logic        n_leap;
    logic [10:0] n_r2;
    logic [1:0]  n_yq;
    logic [10:0] n_doy;
    t_month      n_m;
    logic [8:0]  n_start;

    assign n_p_quad  = 32'(i_days) * 32'(ECAL_QUAD_RECIP);
    assign n_rq_full = r_d4_days - 16'(16'(r_d4_qest) * 16'(ECAL_QUAD_DAYS));
    assign n_rq_ge   = (r_d5_rq >= ECAL_QUAD_DAYS);

    // The first year of a period is leap; the last day of a period lands on 31 December.
    always_comb begin
        n_leap = (r_d6_rem < ECAL_LEAP_DAYS);
        n_r2   = r_d6_rem - ECAL_LEAP_DAYS;
        if (n_leap) begin
            n_yq  = 2'd0;
            n_doy = r_d6_rem;
        end else if (n_r2 >= ECAL_TWO_YEARS) begin
            n_yq  = 2'd3;
            n_doy = n_r2 - ECAL_TWO_YEARS;
        end else if (n_r2 >= ECAL_YEAR_DAYS) begin
            n_yq  = 2'd2;
            n_doy = n_r2 - ECAL_YEAR_DAYS;
        end else begin
            n_yq  = 2'd1;
            n_doy = n_r2;
        end
    end

    // From March on the month starts move one day later in a leap year.
    always_comb begin
        logic [8:0] s;
        n_m     = '0;
        n_start = '0;
        for (int i = 0; i < 12; i++) begin
            s = MONTH_START[i] + ((i >= 2) ? 9'(r_d7_leap) : 9'd0);
            if (r_d7_doy >= s) begin
                n_m     = 4'(i);
                n_start = s;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_d4_days <= i_days;
            r_d4_qest <= n_p_quad[31:26];
        end
        if (i_load[1]) begin
            r_d5_qest <= r_d4_qest;
            r_d5_rq   <= n_rq_full[11:0];
        end
        if (i_load[2]) begin
            r_d6_quad <= r_d5_qest + 6'(n_rq_ge);
            r_d6_rem  <= n_rq_ge ? 11'(r_d5_rq - ECAL_QUAD_DAYS) : r_d5_rq[10:0];
        end
        if (i_load[3]) begin
            r_d7_quad <= r_d6_quad;
            r_d7_yq   <= n_yq;
            r_d7_doy  <= n_doy[8:0];
            r_d7_leap <= n_leap;
        end
        if (i_load[4]) begin
            r_d8_year  <= ECAL_BASE_YEAR + 12'({r_d7_quad, 2'b00}) + 12'(r_d7_yq);
            r_d8_month <= n_m + 4'd1;
            r_d8_dom   <= 5'(r_d7_doy - n_start + 9'd1);
        end
        if (i_load[5]) begin
            r_year  <= r_d8_year;
            r_month <= r_d8_month;
            r_dom   <= r_d8_dom;
        end
    end

    assign o_year         = r_year;
    assign o_month        = r_month;
    assign o_day_of_month = r_dom;

endmodule

`default_nettype wire

[design/ecal_checker.sv]
// Port-level checker for the converter, bound to its top level.
`default_nettype none

module ecal_checker import ecal_pkg::*; (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    input wire logic   i_in_valid,
    input wire logic   i_in_ready,
    input wire logic   i_out_valid,
    input wire logic   i_out_ready,
    input wire t_hour  i_hour,
    input wire t_min   i_minute,
    input wire t_min   i_second,
    input wire t_year  i_year,
    input wire t_month i_month,
    input wire t_dom   i_dom
);

    localparam int CW = $clog2(ECAL_DEPTH + 1);

    // Items accepted but not yet delivered.
    logic [CW-1:0] r_cnt;
    logic          in_acc;
    logic          out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + CW'(in_acc) - CW'(out_acc);
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_hour) &&
        $stable(i_minute) && $stable(i_second) && $stable(i_year) &&
        $stable(i_month) && $stable(i_dom))
        else $error("stalled result changed");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != '0)
        else $error("result without an accepted item");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(ECAL_DEPTH))
        else $error("more items in flight than pipeline stages");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_hour < 5'd24 && i_minute < 6'd60 && i_second < 6'd60 &&
        i_month >= 4'd1 && i_month <= 4'd12 && i_dom >= 5'd1 &&
        i_year >= 12'd1980 && i_year <= 12'd2116)
        else $error("result field out of range");

endmodule

bind epoch_seconds_to_calendar_top ecal_checker u_ecal_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_hour      (o_out.hour),
    .i_minute    (o_out.minute),
    .i_second    (o_out.second),
    .i_year      (o_out.year),
    .i_month     (o_out.month),
    .i_dom       (o_out.day_of_month)
);

`default_nettype wire

[sim/epoch_seconds_to_calendar_top_tb.sv]
// Self-checking testbench for the epoch-seconds to calendar converter.
module epoch_seconds_to_calendar_top_tb import ecal_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // Calendar arithmetic constants. Days count from 1980-01-01, and the
    // epoch itself (1980-01-06) is day five.
    localparam int unsigned DAY_SECS     = 86400;
    localparam int unsigned HOUR_SECS    = 3600;
    localparam int unsigned MIN_SECS     = 60;
    localparam int unsigned EPOCH_DAY    = 5;
    localparam int unsigned PERIOD_DAYS  = 1461;
    localparam int unsigned LEAP_DAYS    = 366;
    localparam int unsigned COMMON_DAYS  = 365;
    localparam int unsigned FIRST_YEAR   = 1980;
    localparam int unsigned LAST_PERIOD  = 34;

    localparam int unsigned MONTH_START [12] = '{
        0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
    };

    localparam int RANDOM_ITEMS = 1600;
    // Near the end of the run both sides run without any idling.
    localparam int CALM_ITEMS   = 150;
    localparam int MAX_REPORTS  = 10;

    // One result item: time of day and calendar date.
    typedef struct packed {
        t_hour  hour;
        t_min   minute;
        t_min   second;
        t_year  year;
        t_month month;
        t_dom   day_of_month;
    } t_cal;

    // One row of the directed table. When has_date is set, the date and
    // time are typed in; otherwise the predictor supplies them.
    typedef struct packed {
        t_epoch secs;
        bit     has_date;
        t_cal   date;
    } t_stim_row;

    localparam t_cal NO_DATE = '0;

    localparam int DIRECTED_ROWS = 23;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        // The epoch itself.
        '{32'd0,          1'b1, '{5'd0, 6'd0, 6'd0, 12'd1980, 4'd1, 5'd6}},
        // The largest count, early in the 2116 leap year.
        '{32'hFFFFFFFF,   1'b1, '{5'd6, 6'd28, 6'd15, 12'd2116, 4'd2, 5'd11}},
        // Carries through seconds, minutes, hours and into the next day.
        '{32'd1,          1'b0, NO_DATE},
        '{32'd59,         1'b0, NO_DATE},
        '{32'd60,         1'b0, NO_DATE},
        '{32'd3599,       1'b0, NO_DATE},
        '{32'd3600,       1'b0, NO_DATE},
        '{32'd86399,      1'b0, NO_DATE},
        '{32'd86400,      1'b0, NO_DATE},
        // Leap day of 1980 and the first of March after it.
        '{32'd4665600,    1'b0, NO_DATE},
        '{32'd4752000,    1'b0, NO_DATE},
        // End of the leap year and the start of a common year.
        '{32'd31104000,   1'b0, NO_DATE},
        '{32'd31190400,   1'b0, NO_DATE},
        // End of February in a common year.
        '{32'd36201600,   1'b0, NO_DATE},
        '{32'd36288000,   1'b0, NO_DATE},
        // Last day of the first four-year period must read 31 December.
        '{32'd125712000,  1'b1, '{5'd0, 6'd0, 6'd0, 12'd1983, 4'd12, 5'd31}},
        '{32'd125798399,  1'b0, NO_DATE},
        '{32'd125798400,  1'b0, NO_DATE},
        // The year 2100 is treated as leap, so 29 February exists.
        '{32'd3791577600, 1'b1, '{5'd0, 6'd0, 6'd0, 12'd2100, 4'd2, 5'd29}},
        // Last second of the last complete period, 2115-12-31.
        '{32'd4291401599, 1'b0, NO_DATE},
        // Alternating and single-bit patterns.
        '{32'h80000000,   1'b0, NO_DATE},
        '{32'h55555555,   1'b0, NO_DATE},
        '{32'hAAAAAAAA,   1'b0, NO_DATE}
    };

    logic clk;
    logic rst_n;

    ecal_in_if  in_ch ();
    ecal_out_if out_ch ();

    epoch_seconds_to_calendar_top u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Dates still owed by the converter, oldest first.
    t_cal dates_due [$];
    int   fault_count = 0;
    // Typed-in date that travels with the item currently on the input.
    bit   date_given;
    t_cal date_typed;
    // Percent chance that the sender pauses before an item.
    int   idle_pct;
    bit   calm = 1'b0;
    t_cal want;
    t_cal got;

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Start day of a month within its year, one day later from March on in a leap year.
    function automatic int unsigned month_first_day(input int unsigned mon, input bit leap);
        return MONTH_START[mon] + ((mon >= 2 && leap) ? 1 : 0);
    endfunction

    // Predicts the date and time of day for one seconds count.
    function automatic t_cal to_calendar(input t_epoch secs);
        int unsigned sod;
        int unsigned days;
        int unsigned period;
        int unsigned rest;
        int unsigned year_in_period;
        int unsigned doy;
        int unsigned mon;
        int unsigned m;
        bit          leap;
        t_cal        r;
        sod    = secs % DAY_SECS;
        days   = secs / DAY_SECS + EPOCH_DAY;
        period = days / PERIOD_DAYS;
        rest   = days % PERIOD_DAYS;
        // The first year of every period is the leap year.
        if (rest < LEAP_DAYS) begin
            year_in_period = 0;
            doy            = rest;
            leap           = 1'b1;
        end else begin
            rest           = rest - LEAP_DAYS;
            year_in_period = 1 + rest / COMMON_DAYS;
            doy            = rest % COMMON_DAYS;
            leap           = 1'b0;
        end
        mon = 0;
        for (m = 1; m < 12; m++) begin
            if (doy >= month_first_day(m, leap)) begin
                mon = m;
            end
        end
        r.hour         = t_hour'(sod / HOUR_SECS);
        r.minute       = t_min'((sod % HOUR_SECS) / MIN_SECS);
        r.second       = t_min'(sod % MIN_SECS);
        r.year         = t_year'(FIRST_YEAR + 4 * period + year_in_period);
        r.month        = t_month'(mon + 1);
        r.day_of_month = t_dom'(doy - month_first_day(mon, leap) + 1);
        return r;
    endfunction

    // Offers one item on the input channel and holds it until it is taken.
    // A random pause may come first, except in the calm tail of the run.
    task automatic offer_item(input t_epoch secs, input bit has_date, input t_cal date);
        if (!calm && $urandom_range(0, 99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.epoch_seconds <= secs;
        date_given          <= has_date;
        date_typed          <= date;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    // Scoreboard. Both channels are sampled at the same edge in one process, so
    // an item taken at an edge is always queued before any result is checked.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                dates_due.push_back(date_given ? date_typed : to_calendar(in_ch.epoch_seconds));
            end
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.hour, out_ch.minute, out_ch.second,
                        out_ch.year, out_ch.month, out_ch.day_of_month};
                if (dates_due.size() == 0) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS) begin
                        $display("%0t: result with nothing expected: %0d-%0d-%0d %0d:%0d:%0d",
                                 $realtime, got.year, got.month, got.day_of_month,
                                 got.hour, got.minute, got.second);
                    end
                end else begin
                    want = dates_due.pop_front();
                    if (got !== want) begin
                        fault_count++;
                        if (fault_count <= MAX_REPORTS) begin
                            $display("%0t: mismatch, expected %0d-%0d-%0d %0d:%0d:%0d",
                                     $realtime, want.year, want.month, want.day_of_month,
                                     want.hour, want.minute, want.second);
                            $display("%0t:           actual   %0d-%0d-%0d %0d:%0d:%0d",
                                     $realtime, got.year, got.month, got.day_of_month,
                                     got.hour, got.minute, got.second);
                        end
                    end
                end
            end
        end
    end

    // Receiver: ready drops for random bursts, separated by stretches of
    // varying length with no stall at all.
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    end

    // Sender: reset, the directed table, then random timestamps.
    initial begin : drive_items
        int     r;
        int     n;
        int     period;
        int     year_in_period;
        int     mon;
        int     day;
        int     sod;
        longint stamp;
        rst_n               <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.epoch_seconds <= '0;
        date_given          <= 1'b0;
        date_typed          <= NO_DATE;
        idle_pct             = 25;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < DIRECTED_ROWS; r++) begin
            offer_item(DIRECTED[r].secs, DIRECTED[r].has_date, DIRECTED[r].date);
        end

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            // Every 64 items the sender switches between no, light and heavy idling.
            if (n % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 10;
                    default: idle_pct = 40;
                endcase
            end
            calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7: begin
                    stamp = $urandom;
                end
                8, 9, 10: begin
                    // The top of the range, in the last partial period.
                    stamp = $urandom_range(32'hFFFFFFFF, 32'hFFE00000);
                end
                default: begin
                    // First day of a month, or the day before it, which lands on
                    // month, year and period ends. Time of day is often at an end too.
                    period         = $urandom_range(0, LAST_PERIOD);
                    year_in_period = $urandom_range(0, 3);
                    mon            = $urandom_range(0, 11);
                    day = period * PERIOD_DAYS
                        + ((year_in_period == 0) ? 0
                                                 : LEAP_DAYS + COMMON_DAYS * (year_in_period - 1))
                        + month_first_day(mon, year_in_period == 0)
                        - $urandom_range(0, 1);
                    case ($urandom_range(0, 3))
                        0:       sod = 0;
                        1:       sod = DAY_SECS - 1;
                        default: sod = $urandom_range(0, DAY_SECS - 1);
                    endcase
                    if (day < EPOCH_DAY) begin
                        day = EPOCH_DAY;
                    end
                    stamp = longint'(day - EPOCH_DAY) * DAY_SECS + sod;
                    if (stamp > 64'h00000000FFFFFFFF) begin
                        stamp = $urandom;
                    end
                end
            endcase
            offer_item(t_epoch'(stamp), 1'b0, NO_DATE);
        end
        in_ch.valid <= 1'b0;

        // Drain: every expected date must arrive, then nothing more may follow.
        while (dates_due.size() != 0) @(posedge clk);
        repeat (4 * ECAL_DEPTH) @(posedge clk);
        if (fault_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: a correct run with the worst idling ends well before this.
    initial begin
        #(5_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
